// ===== src/utf8dc_pkg.sv =====
// Shared constants for the UTF-8 decode and count unit.
// No dependencies; imported by utf8_decode_and_count_unit.
`timescale 1ns / 1ps
`default_nettype none

package utf8dc_pkg;

  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned POS_BITS   = 16;
  localparam int unsigned CP_BITS    = 16;

  localparam logic [1:0] ST_CHAR  = 2'd0;
  localparam logic [1:0] ST_END   = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;
  localparam logic [1:0] ST_LIMIT = 2'd3;

  localparam logic CFG_LIMIT_ENABLE = 1'b0;
  localparam logic CFG_BYTE_LIMIT   = 1'b1;

  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

endpackage

`default_nettype wire

// ===== src/utf8_decode_and_count_unit.sv =====
// UTF-8 decoder and character counter: one string byte per transaction in,
// at most one decoded character, end, malformed or limit result out.
// Depends on utf8dc_pkg.
// Results are registered: each appears on the output register in the cycle after its byte is accepted.
// Throughput: one byte per cycle; a stalled output holds one result and
// blocks input only while it is not taken.
// Reset: synchronous, active low; clears string state, output valid and sets
// limit_enable to 0 and byte_limit to 0xFFFF.
`timescale 1ns / 1ps
`default_nettype none

module utf8_decode_and_count_unit
  import utf8dc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [15:0] code_point, [31:16] char_count, [47:32] end_offset
  output logic [1:0]       out_tuser,  // [1:0] status
  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic [15:0] cfg_wdata
);

  logic                  limit_en_r;
  logic [POS_BITS-1:0]   byte_limit_r;

  logic [1:0]            pend_r, pend_nxt;
  logic [CP_BITS-1:0]    acc_r, acc_nxt;
  logic [POS_BITS-1:0]   pos_r, pos_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic                  discard_r, discard_nxt;

  logic                  out_valid_r;
  logic [CP_BITS-1:0]    code_r, code_nxt;
  logic [1:0]            status_r, status_nxt;
  logic [15:0]           cnt_out_r;
  logic [POS_BITS-1:0]   end_r, end_nxt;
  logic                  emit;

  logic                  accept;
  logic [7:0]            b;
  logic [POS_BITS-1:0]   pos_adv;
  logic [COUNT_BITS-1:0] count_inc;
  logic [15:0]           count_low;
  logic [CP_BITS-1:0]    acc_shift;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign b         = in_tdata;
  assign pos_adv   = (pos_r != POS_MAX) ? pos_r + 1'b1 : pos_r;
  assign count_inc = (count_r != {COUNT_BITS{1'b1}}) ? count_r + 1'b1 : count_r;
  assign acc_shift = {acc_r[CP_BITS-7:0], b[5:0]};

  generate
    if (COUNT_BITS >= 16) begin : g_cnt_trunc
      assign count_low = count_r[15:0];
    end else begin : g_cnt_ext
      assign count_low = {{(16-COUNT_BITS){1'b0}}, count_r};
    end
  endgenerate

  always_comb begin
    pend_nxt    = pend_r;
    acc_nxt     = acc_r;
    pos_nxt     = pos_r;
    count_nxt   = count_r;
    discard_nxt = discard_r;
    emit        = 1'b0;
    code_nxt    = '0;
    status_nxt  = ST_CHAR;
    end_nxt     = pos_adv;

    if (discard_r) begin
      if (b == 8'h00) begin
        pend_nxt    = '0;
        acc_nxt     = '0;
        pos_nxt     = '0;
        count_nxt   = '0;
        discard_nxt = 1'b0;
      end
    end else if (b == 8'h00) begin
      emit        = 1'b1;
      status_nxt  = ST_END;
      end_nxt     = pos_r;
      pend_nxt    = '0;
      acc_nxt     = '0;
      pos_nxt     = '0;
      count_nxt   = '0;
    end else begin
      pos_nxt = pos_adv;
      if (pend_r == 2'd0) begin
        if (b[7] == 1'b0) begin
          emit     = 1'b1;
          code_nxt = {{(CP_BITS-8){1'b0}}, b};
        end else if (b[7:5] == 3'b110) begin
          acc_nxt  = {{(CP_BITS-5){1'b0}}, b[4:0]};
          pend_nxt = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          acc_nxt  = {{(CP_BITS-4){1'b0}}, b[3:0]};
          pend_nxt = 2'd2;
        end else begin
          emit        = 1'b1;
          status_nxt  = ST_BAD;
          discard_nxt = 1'b1;
        end
      end else if (b[7:6] != 2'b10) begin
        emit        = 1'b1;
        status_nxt  = ST_BAD;
        discard_nxt = 1'b1;
        pend_nxt    = '0;
      end else begin
        acc_nxt  = acc_shift;
        pend_nxt = pend_r - 1'b1;
        if (pend_r == 2'd1) begin
          emit     = 1'b1;
          code_nxt = acc_shift;
        end
      end
      // finish a completed character: limit check, then count
      if (emit && status_nxt == ST_CHAR) begin
        if (limit_en_r && (pos_adv > byte_limit_r)) begin
          status_nxt  = ST_LIMIT;
          code_nxt    = '0;
          discard_nxt = 1'b1;
          pend_nxt    = '0;
        end else begin
          count_nxt = count_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_en_r   <= 1'b0;
      byte_limit_r <= POS_MAX;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_LIMIT_ENABLE: limit_en_r   <= cfg_wdata[0];
        CFG_BYTE_LIMIT:   byte_limit_r <= cfg_wdata[POS_BITS-1:0];
        default:          limit_en_r   <= limit_en_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r    <= '0;
      acc_r     <= '0;
      pos_r     <= '0;
      count_r   <= '0;
      discard_r <= 1'b0;
    end else if (accept) begin
      pend_r    <= pend_nxt;
      acc_r     <= acc_nxt;
      pos_r     <= pos_nxt;
      count_r   <= count_nxt;
      discard_r <= discard_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      code_r    <= code_nxt;
      status_r  <= status_nxt;
      cnt_out_r <= count_low;
      end_r     <= end_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {end_r, cnt_out_r, code_r};
  assign out_tuser  = status_r;

`ifndef NO_ASSERTIONS
  a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r != ST_CHAR) |-> (code_r == '0))
    else $error("code_point non-zero on a non-character result");

  a_pend_range: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("pending continuation count out of range");

  a_discard_idle: assert property (@(posedge clk) disable iff (!rst_n)
    discard_r |-> (pend_r == 2'd0))
    else $error("discarding with a sequence still pending");

  a_nul_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_tdata == 8'h00) |=> (pos_r == '0) && (count_r == '0) && !discard_r)
    else $error("string state not cleared after NUL");
`endif

endmodule

`default_nettype wire

// ===== dv/utf8_decode_and_count_unit_tb.sv =====
// Testbench for utf8_decode_and_count_unit: random and directed byte strings in,
// each result checked field by field against an in-bench decoder model.
// Depends on utf8dc_pkg and the unit itself; needs no files or arguments.
`timescale 1ns / 1ps

module utf8_decode_and_count_unit_tb;
  import utf8dc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  localparam logic [7:0] DIRECTED [25] = '{
    8'hC2, 8'hA9, 8'hEF, 8'hBF, 8'hBF, 8'h7F, 8'h01, 8'h00,
    8'hE0, 8'h80, 8'h80, 8'hDF, 8'hBF, 8'hC3, 8'h00,
    8'h80, 8'h41, 8'h00,
    8'hF0, 8'h00,
    8'hC3, 8'h41, 8'h00,
    8'hFF, 8'h00
  };

  localparam logic [7:0] OVER_LIMIT [6] = '{8'h41, 8'h41, 8'hE2, 8'h82, 8'hAC, 8'h00};

  typedef struct packed {
    logic [CP_BITS-1:0]  cp;
    logic [1:0]          st;
    logic [15:0]         cnt;
    logic [POS_BITS-1:0] off;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;     // [7:0] data_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;            // [15:0] code_point, [31:16] char_count, [47:32] end_offset
  logic [1:0]  out_tuser;            // [1:0] status
  logic        cfg_we = 1'b0;
  logic        cfg_addr = 1'b0;
  logic [15:0] cfg_wdata = 16'h0000;

  logic [7:0] tx_bytes [$];
  result_t    decoded_q [$];

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned cycle_cnt = 0;
  int unsigned errors = 0;
  int unsigned bytes_sent = 0;
  int unsigned results_seen = 0;
  int unsigned status_seen [4] = '{0, 0, 0, 0};

  // decoder model state
  logic [1:0]            cont_left = '0;
  logic [CP_BITS-1:0]    code_acc = '0;
  logic [POS_BITS-1:0]   str_pos = '0;
  logic [COUNT_BITS-1:0] char_cnt = '0;
  logic                  skipping = 1'b0;
  logic                  limit_on = 1'b0;
  logic [15:0]           limit_bytes = 16'hFFFF;

  utf8_decode_and_count_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #4 clk = ~clk;

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  function automatic logic [POS_BITS-1:0] step_pos();
    if (str_pos != POS_MAX) str_pos++;
    return str_pos;
  endfunction

  task automatic clear_string();
    cont_left = '0;
    code_acc  = '0;
    str_pos   = '0;
    char_cnt  = '0;
    skipping  = 1'b0;
  endtask

  task automatic expect_result(input logic [CP_BITS-1:0] cp, input logic [1:0] st,
                               input logic [POS_BITS-1:0] off);
    decoded_q.push_back({cp, st, char_cnt[15:0], off});
  endtask

  task automatic finish_char(input logic [CP_BITS-1:0] cp, input logic [POS_BITS-1:0] stop);
    if (limit_on && stop > limit_bytes) begin
      skipping  = 1'b1;
      cont_left = '0;
      expect_result('0, ST_LIMIT, stop);
    end else begin
      expect_result(cp, ST_CHAR, stop);
      if (char_cnt != {COUNT_BITS{1'b1}}) char_cnt++;
    end
  endtask

  task automatic flag_bad();
    logic [POS_BITS-1:0] stop;
    stop      = step_pos();
    skipping  = 1'b1;
    cont_left = '0;
    expect_result('0, ST_BAD, stop);
  endtask

  task automatic decode_byte(input logic [7:0] b);
    logic [POS_BITS-1:0] stop;
    if (skipping) begin
      if (b == 8'h00) clear_string();
    end else if (b == 8'h00) begin
      expect_result('0, ST_END, str_pos);
      clear_string();
    end else if (cont_left == 2'd0) begin
      if (!b[7]) begin
        stop = step_pos();
        finish_char({8'h00, b}, stop);
      end else if (b[7:5] == 3'b110) begin
        code_acc  = {11'd0, b[4:0]};
        cont_left = 2'd1;
        void'(step_pos());
      end else if (b[7:4] == 4'b1110) begin
        code_acc  = {12'd0, b[3:0]};
        cont_left = 2'd2;
        void'(step_pos());
      end else begin
        flag_bad();
      end
    end else if (b[7:6] != 2'b10) begin
      flag_bad();
    end else begin
      code_acc  = {code_acc[9:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      stop      = step_pos();
      if (cont_left == 2'd0) finish_char(code_acc, stop);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    errors++;
    if (errors <= 40)
      $display("%0t: %s mismatch, got %h, want %h", $time, what, got, want);
  endtask

  // sender: advance the byte queue on each accepted transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        decode_byte(in_tdata);
        bytes_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (tx_bytes.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= tx_bytes.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: check each accepted result against the oldest prediction
  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
      if (out_tvalid && out_tready) begin
        got = {out_tdata[15:0], out_tuser, out_tdata[31:16], out_tdata[47:32]};
        results_seen++;
        status_seen[got.st]++;
        if (decoded_q.size() == 0) begin
          report_mismatch("unexpected result, status", {14'd0, got.st}, 16'h0000);
        end else begin
          want = decoded_q.pop_front();
          if (got.st != want.st) report_mismatch("status", {14'd0, got.st}, {14'd0, want.st});
          if (got.cp != want.cp) report_mismatch("code_point", got.cp, want.cp);
          if (got.cnt != want.cnt) report_mismatch("char_count", got.cnt, want.cnt);
          if (got.off != want.off) report_mismatch("end_offset", got.off, want.off);
        end
      end
    end
  end

  task automatic wait_idle();
    while (tx_bytes.size() != 0 || in_tvalid || decoded_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(input logic en, input logic [15:0] lim,
                           input int unsigned idle, input int unsigned stall);
    wait_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_LIMIT_ENABLE;
    cfg_wdata <= {15'd0, en};
    @(posedge clk);
    cfg_addr  <= CFG_BYTE_LIMIT;
    cfg_wdata <= lim;
    @(posedge clk);
    cfg_we      <= 1'b0;
    limit_on    = en;
    limit_bytes = lim;
    idle_pct    = idle;
    stall_pct   = stall;
  endtask

  task automatic queue_random_string(output int unsigned added);
    logic [7:0]  s [$];
    int unsigned mode;
    int unsigned at;
    repeat ($urandom_range(10)) begin
      case ($urandom_range(2))
        0: s.push_back(8'($urandom_range(127, 1)));
        1: begin
          s.push_back(8'hC0 | 8'($urandom_range(31)));
          s.push_back(8'h80 | 8'($urandom_range(63)));
        end
        default: begin
          s.push_back(8'hE0 | 8'($urandom_range(15)));
          s.push_back(8'h80 | 8'($urandom_range(63)));
          s.push_back(8'h80 | 8'($urandom_range(63)));
        end
      endcase
    end
    mode = $urandom_range(99);
    at   = $urandom_range(s.size());
    if (mode < 6) begin
      while (s.size() > at) void'(s.pop_back());
    end else if (mode < 12) begin
      s.insert(at, 8'($urandom_range(255, 128)));
    end else if (mode < 16 && s.size() != 0) begin
      s[$urandom_range(s.size() - 1)] = 8'($urandom_range(255, 1));
    end else if (mode < 20) begin
      repeat ($urandom_range(6, 1)) s.push_front(8'($urandom_range(255)));
    end
    s.push_back(8'h00);
    added = s.size();
    foreach (s[i]) tx_bytes.push_back(s[i]);
  endtask

  task automatic queue_random(input int unsigned budget);
    int unsigned queued;
    int unsigned n;
    queued = 0;
    while (queued < budget) begin
      queue_random_string(n);
      queued += n;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    configure(1'b0, 16'hFFFF, 0, 0);
    foreach (DIRECTED[i]) tx_bytes.push_back(DIRECTED[i]);
    queue_random(150);

    configure(1'b1, 16'd4, 75, 0);
    foreach (OVER_LIMIT[i]) tx_bytes.push_back(OVER_LIMIT[i]);
    queue_random(150);

    configure(1'b1, 16'd0, 0, 75);
    queue_random(100);

    configure(1'b1, 16'hFFFF, 31, 31);
    queue_random(130);

    configure(1'b0, 16'd0, 0, 0);
    queue_random(60);

    wait_idle();
    $display("Sent %0d bytes, checked %0d results: %0d chars, %0d ends, %0d malformed, %0d limit",
             bytes_sent, results_seen, status_seen[ST_CHAR], status_seen[ST_END],
             status_seen[ST_BAD], status_seen[ST_LIMIT]);
    $display("Five limit settings and four idle/stall mixes over directed and random strings");
    if (errors == 0) begin
      $display("** utf8_decode_and_count_unit: PASSED **");
    end else begin
      $display("** utf8_decode_and_count_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles, %0d results still awaited", cycle_cnt, decoded_q.size());
    $display("** utf8_decode_and_count_unit: FAILED **");
    $finish;
  end

endmodule
